@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kcl_pkg.sv @@
package kcl_pkg;

  localparam int CODE_DIGITS = 4;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int CODE_VEC_W  = (4 * CODE_DIGITS > 16) ? 4 * CODE_DIGITS : 16;
  localparam int DIGITS_W    = 3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;
  localparam logic [7:0] CHAR_BS   = 8'h08;

  localparam logic [15:0] SECRET_RST     = 16'd4369;
  localparam logic [15:0] ENTRY_TO_RST   = 16'd100;
  localparam logic [15:0] OPEN_TICKS_RST = 16'd100;
  localparam logic [7:0]  BLINK_HALF_RST = 8'd5;

  typedef enum logic [1:0] {
    MODE_LOCKED   = 2'd0,
    MODE_ENTERING = 2'd1,
    MODE_UNLOCKED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_BYTE   = 2'd1,
    FUNC_BUTTON = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_DIGIT   = 4'd1,
    EV_ERASED  = 4'd2,
    EV_CORRECT = 4'd3,
    EV_WRONG   = 4'd4,
    EV_SHORT   = 4'd5,
    EV_PROMPT  = 4'd6,
    EV_OPEN    = 4'd7,
    EV_TIMEOUT = 4'd8,
    EV_CLOSED  = 4'd9
  } event_e;

  typedef enum logic [1:0] {
    CFG_SECRET     = 2'd0,
    CFG_ENTRY_TO   = 2'd1,
    CFG_OPEN_TICKS = 2'd2,
    CFG_BLINK_HALF = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] secret_code;
    logic [15:0] entry_timeout_ticks;
    logic [15:0] open_ticks;
    logic [7:0]  blink_half_ticks;
  } cfg_t;

  // Packed so that relay_on lands in bit 0.
  typedef struct packed {
    logic [3:0]          event_code;
    logic [DIGITS_W-1:0] digits_held;
    logic [1:0]          lock_mode;
    logic                led_on;
    logic                relay_on;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

@@ rtl/kcl_core.sv @@
`include "assert_macros.svh"

module kcl_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        rx_byte_i,
  input  kcl_pkg::cfg_t     cfg_i,
  output kcl_pkg::res_t     res_o
);
  import kcl_pkg::*;

  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [8:0]       blink_q, blink_d;
  logic             relay_q, relay_d;
  logic             led_q, led_d;
  logic [3:0]       store_q [CODE_DIGITS];
  logic             store_we;
  event_e           ev;

  logic             is_tick, is_byte, is_button;
  logic             is_digit, is_erase, buf_full, code_ok;
  logic             entry_expired, open_expired;
  logic [15:0]      elapsed_sat;
  logic [CODE_VEC_W-1:0] code_vec;
  logic [8:0]       half, half_dbl, blink_inc;

  // Decode the item and the timer conditions.
  always_comb begin
    is_tick   = 1'b0;
    is_byte   = 1'b0;
    is_button = 1'b0;
    case (func_i)
      FUNC_TICK:   is_tick   = 1'b1;
      FUNC_BYTE:   is_byte   = 1'b1;
      FUNC_BUTTON: is_button = 1'b1;
      default: ;
    endcase
    is_digit    = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
    is_erase    = (rx_byte_i == CHAR_DEL) || (rx_byte_i == CHAR_BS);
    buf_full    = (count_q >= CNT_W'(CODE_DIGITS));
    elapsed_sat = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
    entry_expired = (mode_q == MODE_ENTERING) && (elapsed_sat >= cfg_i.entry_timeout_ticks);
    open_expired  = (mode_q == MODE_UNLOCKED) && (elapsed_sat >= cfg_i.open_ticks);
  end

  // First digit sits in the top nibble; positions beyond the register read as zero.
  always_comb begin
    code_vec = CODE_VEC_W'(cfg_i.secret_code);
    code_ok  = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (store_q[i] != code_vec[4*(CODE_DIGITS-1-i) +: 4]) begin
        code_ok = 1'b0;
      end
    end
  end

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    if (step_i) begin
      if (is_tick) begin
        if (entry_expired || open_expired) begin
          mode_d = MODE_LOCKED;
        end
      end else if (is_byte && mode_q != MODE_UNLOCKED) begin
        if (is_digit && !buf_full) begin
          mode_d = MODE_ENTERING;
        end else if (is_erase && count_q == CNT_W'(1)) begin
          mode_d = MODE_LOCKED;
        end
      end else if (is_button && mode_q == MODE_ENTERING && !buf_full) begin
        mode_d = mode_q;
      end else if (is_button && mode_q == MODE_ENTERING) begin
        mode_d = code_ok ? MODE_UNLOCKED : MODE_LOCKED;
      end
    end
  end

  // Datapath updates and event code.
  always_comb begin
    count_d   = count_q;
    elapsed_d = elapsed_q;
    blink_d   = blink_q;
    relay_d   = relay_q;
    led_d     = led_q;
    store_we  = 1'b0;
    ev        = EV_NONE;
    half      = (cfg_i.blink_half_ticks == 8'd0) ? 9'd1 : {1'b0, cfg_i.blink_half_ticks};
    half_dbl  = half << 1;
    blink_inc = blink_q + 9'd1;
    if (step_i) begin
      if (is_tick) begin
        if (mode_q != MODE_LOCKED) begin
          elapsed_d = elapsed_sat;
        end
        if (entry_expired) begin
          count_d = '0;
          ev      = EV_TIMEOUT;
        end else if (open_expired) begin
          relay_d = 1'b0;
          ev      = EV_CLOSED;
        end
        if (mode_d == MODE_UNLOCKED) begin
          led_d   = (blink_q >= half);
          blink_d = (blink_inc >= half_dbl) ? 9'd0 : blink_inc;
        end else begin
          led_d = 1'b1;
        end
      end else if (is_byte && mode_q != MODE_UNLOCKED) begin
        if (is_digit && !buf_full) begin
          if (mode_q == MODE_LOCKED) begin
            elapsed_d = '0;
          end
          store_we = 1'b1;
          count_d  = count_q + CNT_W'(1);
          ev       = EV_DIGIT;
        end else if (is_erase && count_q != '0) begin
          count_d = count_q - CNT_W'(1);
          ev      = EV_ERASED;
        end
      end else if (is_button) begin
        case (mode_q)
          MODE_ENTERING: begin
            if (!buf_full) begin
              ev = EV_SHORT;
            end else begin
              count_d = '0;
              if (code_ok) begin
                relay_d   = 1'b1;
                elapsed_d = '0;
                ev        = EV_CORRECT;
              end else begin
                ev = EV_WRONG;
              end
            end
          end
          MODE_UNLOCKED: ev = EV_OPEN;
          default:       ev = EV_PROMPT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_LOCKED;
      count_q   <= '0;
      elapsed_q <= '0;
      blink_q   <= '0;
      relay_q   <= 1'b0;
      led_q     <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
      blink_q   <= blink_d;
      relay_q   <= relay_d;
      led_q     <= led_d;
    end
  end

  // Only positions written since entry began are ever compared.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[IDX_W-1:0]] <= rx_byte_i[3:0];
    end
  end

  always_comb begin
    res_o.event_code  = ev;
    res_o.digits_held = DIGITS_W'(count_d);
    res_o.lock_mode   = mode_d;
    res_o.led_on      = led_d;
    res_o.relay_on    = relay_d;
  end

  `ASSERT_ALWAYS(a_relay_iff_unlocked, relay_q == (mode_q == MODE_UNLOCKED),
    "relay level disagrees with lock mode")
  `ASSERT_ALWAYS(a_digits_only_entering,
    (mode_q == MODE_ENTERING) ? (count_q != '0) : (count_q == '0),
    "digit count inconsistent with lock mode")
  `ASSERT_ALWAYS(a_led_lit_when_locked, (mode_q == MODE_UNLOCKED) || led_q,
    "LED dark outside unlocked mode")
  `ASSERT_NEXT(a_idle_holds_state, !step_i,
    $stable(mode_q) && $stable(count_q) && $stable(elapsed_q),
    "lock state moved without a transaction")

endmodule

@@ rtl/keypad_code_lock_unit.sv @@
// A transaction accepted into the input register is stepped through the core and its
// result loaded into the result register once that register is free or being drained.
// Throughput: one transaction per cycle while the output is not stalled; when both
// registers are full the input is ready only in a cycle in which the waiting result is taken.
// Reset (rst_ni, asynchronous, active low): lock locked, no digits, counters zero,
// relay off, LED on, configuration registers back to their default values.
`include "assert_macros.svh"

module keypad_code_lock_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [15:0]               cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]                s_axis_tuser,   // [1:0] func
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata    // [0] relay_on, [1] led_on,
                                                    // [3:2] lock_mode, [6:4] digits_held,
                                                    // [10:7] event_code, [15:11] zero
);
  import kcl_pkg::*;

  cfg_t       cfg_q;
  logic       in_v_q;
  logic [1:0] func_q;
  logic [7:0] byte_q;
  logic       out_v_q;
  res_t       res_q, res_d;
  logic       adv;
  logic       in_take;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.secret_code         <= SECRET_RST;
      cfg_q.entry_timeout_ticks <= ENTRY_TO_RST;
      cfg_q.open_ticks          <= OPEN_TICKS_RST;
      cfg_q.blink_half_ticks    <= BLINK_HALF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SECRET:     cfg_q.secret_code         <= cfg_wdata_i;
        CFG_ENTRY_TO:   cfg_q.entry_timeout_ticks <= cfg_wdata_i;
        CFG_OPEN_TICKS: cfg_q.open_ticks          <= cfg_wdata_i;
        CFG_BLINK_HALF: cfg_q.blink_half_ticks    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on transaction, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  kcl_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .func_i    (func_q),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(16 - RES_W)'(0), res_q};

  `ASSERT_ALWAYS(a_no_input_overwrite, !(in_take && in_v_q) || adv,
    "input register overwritten before it advanced")
  `ASSERT_NEXT(a_result_loaded, adv, out_v_q && !in_v_q || out_v_q && $past(in_take),
    "advanced item did not reach the result register")

endmodule
